// File: sv/tef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoidal energy filter package
// Shared widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package tef_pkg;

  // Default values of the top-level parameters.
  localparam int DELAY_DEPTH_DEF = 4096;
  localparam int MAX_RECORD_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration channel widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Result field width.
  localparam int RESULT_W = 32;

  // Width of a tap delay (up to 2*rise_len + gap_len).
  localparam int TAP_KEY_W = 12;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RISE_LEN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LEN       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLAT_OFFSET   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_AVG_COUNT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLE_ZERO_M   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NORM_GAIN     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_AVG_COUNT = 3'd6;

  // Register reset values.
  localparam logic [9:0]  RISE_LEN_RST      = 10'd16;
  localparam logic [9:0]  GAP_LEN_RST       = 10'd8;
  localparam logic [10:0] FLAT_OFFSET_RST   = 11'd8;
  localparam logic [9:0]  AVG_COUNT_RST     = 10'd4;
  localparam logic [31:0] POLE_ZERO_M_RST   = 32'd65536;
  localparam logic [31:0] NORM_GAIN_RST     = 32'd65536;
  localparam logic [23:0] INV_AVG_COUNT_RST = 24'd4194304;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAP0,
    ST_TAP1,
    ST_TAP2,
    ST_DIFF,
    ST_MULM,
    ST_RSUM,
    ST_SACC,
    ST_ELO,
    ST_EHI,
    ST_EADD,
    ST_WIN,
    ST_PLO,
    ST_PHI,
    ST_PADD,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: sv/tef_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoidal energy filter channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------

// Sample channel: one beat carries one waveform sample and its start flag.
interface tef_in_if #(
  parameter int SAMPLE_BITS = tef_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

// Result channel: one beat per accepted sample.
interface tef_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tef_pkg::RESULT_W-1:0]  energy;
  logic signed [tef_pkg::RESULT_W-1:0]  peak_height;
  logic                                 peak_valid;

  modport source (output valid, energy, peak_height, peak_valid, input ready);
  modport sink   (input valid, energy, peak_height, peak_valid, output ready);
endinterface

// Configuration write channel.
interface tef_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tef_pkg::CFG_INDEX_W-1:0]    index;
  logic [tef_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/trapezoidal_energy_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trapezoidal energy filter unit
// Trapezoid shaper with pole-zero correction and flat-top peak averaging,
// built around a single-port-read delay store and a shared multiply sequence.
// ----------------------------------------------------------------------------
// Sequence: a sample in a record runs the three tap reads, the difference, the
// pole-zero multiply, the sums, the energy scaling and the window step; the one
// that closes the peak window also runs the peak scaling, and one outside a
// record goes straight to the result step. A sample is taken only when idle;
// the tap reads share the delay store's one read port, the multiplies run in turn.
// Reset: synchronous; no record is active, registers take their defaults and
// the delay store is not cleared (entries are written before being read).
// ----------------------------------------------------------------------------
module trapezoidal_energy_filter_unit #(
  parameter int DELAY_DEPTH = tef_pkg::DELAY_DEPTH_DEF,
  parameter int MAX_RECORD  = tef_pkg::MAX_RECORD_DEF,
  parameter int SAMPLE_BITS = tef_pkg::SAMPLE_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  tef_in_if.sink     data_in,
  tef_out_if.source  data_out,
  tef_cfg_if.sink    cfg
);

  import tef_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int SW  = $clog2(MAX_RECORD + 1);
  localparam int KW  = TAP_KEY_W;
  localparam int CW  = (SW > KW) ? SW : KW;
  localparam int TW  = CW + 1;
  localparam int DW  = SAMPLE_BITS + 2;
  localparam int PMW = DW + 33;

  // Configuration registers.
  logic [9:0]  rise_len;
  logic [9:0]  gap_len;
  logic [10:0] flat_offset;
  logic [9:0]  avg_count;
  logic [31:0] pole_zero_m;
  logic [31:0] norm_gain;
  logic [23:0] inv_avg_count;

  // Control state.
  state_t      state, state_next;
  logic [AW-1:0] write_pointer;
  logic [SW-1:0] since_start;
  logic        active;
  logic        run_q;
  logic        in_win_q;
  logic        at_end_q;

  // Datapath registers.
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] tap_a;
  logic signed [SAMPLE_BITS-1:0] tap_b;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic                          rd_zero_q;
  logic signed [DW-1:0]          d_q;
  logic [31:0]                   running_diff_sum;
  logic signed [PMW-1:0]         pm_q;
  logic [63:0]                   r_q;
  logic [63:0]                   shaper_accum;
  logic [63:0]                   elo_q;
  logic [47:0]                   ehi_q;
  logic [31:0]                   energy_q;
  logic [47:0]                   window_sum;
  logic [47:0]                   plo_q;
  logic [31:0]                   phi_q;
  logic [31:0]                   peak_q;

  // Result register.
  logic        out_valid;
  logic [31:0] out_energy;
  logic [31:0] out_peak;
  logic        out_peak_valid;

  // Delay store.
  logic signed [SAMPLE_BITS-1:0] delay_store [DELAY_DEPTH];

  // Combinational signals.
  logic          in_fire;
  logic          out_free;
  logic          done_fire;
  logic [KW-1:0] key_r, key_l, key_rl, rd_key;
  logic [AW-1:0] rd_addr;
  logic signed [SAMPLE_BITS-1:0] tap_now;
  logic signed [DW-1:0]          d_now;
  logic [TW-1:0] t_now, t_end;
  logic signed [PMW-1:0]         pm_prod;
  logic [63:0]                   elo_prod;
  logic signed [64:0]            ehi_prod;
  logic [47:0]                   energy_sum;
  logic [47:0]                   plo_prod;
  logic signed [48:0]            phi_prod;
  logic [SW-1:0]                 since_next;

  // Reduce a tap delay modulo the store depth by conditional subtraction.
  function automatic logic [AW-1:0] wrap_delay(input logic [KW-1:0] k);
    logic [KW-1:0] r;
    r = k;
    for (int j = KW - 1; j >= 0; j--) begin
      if ((longint'(DELAY_DEPTH) << j) < (longint'(1) << KW)) begin
        if (r >= KW'(longint'(DELAY_DEPTH) << j)) begin
          r = r - KW'(longint'(DELAY_DEPTH) << j);
        end
      end
    end
    return AW'(r);
  endfunction

  // Store address of the sample k places back from the write pointer.
  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                             input logic [KW-1:0] k);
    logic [AW:0] sum;
    sum = {1'b0, wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, wrap_delay(k)};
    if (sum >= (AW+1)'(DELAY_DEPTH)) begin
      sum = sum - (AW+1)'(DELAY_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Handshakes.
  assign cfg.ready      = 1'b1;
  assign out_free       = !out_valid || data_out.ready;
  assign in_fire        = data_in.valid && data_in.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_len      <= RISE_LEN_RST;
      gap_len       <= GAP_LEN_RST;
      flat_offset   <= FLAT_OFFSET_RST;
      avg_count     <= AVG_COUNT_RST;
      pole_zero_m   <= POLE_ZERO_M_RST;
      norm_gain     <= NORM_GAIN_RST;
      inv_avg_count <= INV_AVG_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_RISE_LEN:      rise_len      <= cfg.data[9:0];
        CFG_GAP_LEN:       gap_len       <= cfg.data[9:0];
        CFG_FLAT_OFFSET:   flat_offset   <= cfg.data[10:0];
        CFG_AVG_COUNT:     avg_count     <= cfg.data[9:0];
        CFG_POLE_ZERO_M:   pole_zero_m   <= cfg.data;
        CFG_NORM_GAIN:     norm_gain     <= cfg.data;
        CFG_INV_AVG_COUNT: inv_avg_count <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // Tap delays R, R+G and 2R+G, with R = rise_len and G = gap_len.
  assign key_r  = KW'(rise_len);
  assign key_l  = KW'(rise_len) + KW'(gap_len);
  assign key_rl = key_r + key_l;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = (active || data_in.start_req) ? ST_TAP0 : ST_DONE;
        end
      end
      ST_TAP0: state_next = ST_TAP1;
      ST_TAP1: state_next = ST_TAP2;
      ST_TAP2: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_MULM;
      ST_MULM: state_next = ST_RSUM;
      ST_RSUM: state_next = ST_SACC;
      ST_SACC: state_next = ST_ELO;
      ST_ELO:  state_next = ST_EHI;
      ST_EHI:  state_next = ST_EADD;
      ST_EADD: state_next = ST_WIN;
      ST_WIN:  state_next = at_end_q ? ST_PLO : ST_DONE;
      ST_PLO:  state_next = ST_PHI;
      ST_PHI:  state_next = ST_PADD;
      ST_PADD: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State-dependent outputs: input ready, read tap selection, result load.
  always_comb begin
    data_in.ready = 1'b0;
    rd_key        = key_r;
    done_fire     = 1'b0;
    case (state)
      ST_IDLE: data_in.ready = 1'b1;
      ST_TAP0: rd_key = key_r;
      ST_TAP1: rd_key = key_l;
      ST_TAP2: rd_key = key_rl;
      ST_DONE: done_fire = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Delay store: write on the accepted beat, one tap read per cycle.
  assign rd_addr = tap_addr(write_pointer, rd_key);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      delay_store[write_pointer] <= data_in.sample[SAMPLE_BITS-1:0];
    end
    rd_q <= delay_store[rd_addr];
  end

  // Taps reaching before the start read as zero.
  always_ff @(posedge clk) begin
    rd_zero_q <= CW'(since_start) < CW'(rd_key);
  end

  assign tap_now = rd_zero_q ? '0 : rd_q;

  // Tap difference and window position for this sample.
  assign d_now = DW'(x_q) - DW'(tap_a) - DW'(tap_b) + DW'(tap_now);
  assign t_now = TW'(since_start);
  assign t_end = TW'(rise_len) + TW'(flat_offset);

  // Multipliers, each feeding a register.
  assign pm_prod  = $signed({1'b0, pole_zero_m}) * d_q;
  assign elo_prod = shaper_accum[31:0] * norm_gain;
  assign ehi_prod = $signed(shaper_accum[63:32]) * $signed({1'b0, norm_gain});
  assign plo_prod = window_sum[23:0] * inv_avg_count;
  assign phi_prod = $signed(window_sum[47:24]) * $signed({1'b0, inv_avg_count});

  // Bits 32 and up of the scaled accumulator; low product bits carry nothing.
  assign energy_sum = ehi_q + {16'h0, elo_q[63:32]};

  assign since_next = since_start + SW'(1);

  // Filter datapath and record state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer    <= '0;
      since_start      <= '0;
      active           <= 1'b0;
      run_q            <= 1'b0;
      running_diff_sum <= '0;
      shaper_accum     <= '0;
      window_sum       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            x_q   <= data_in.sample[SAMPLE_BITS-1:0];
            run_q <= active || data_in.start_req;
            if (data_in.start_req) begin
              active           <= 1'b1;
              since_start      <= '0;
              running_diff_sum <= '0;
              shaper_accum     <= '0;
              window_sum       <= '0;
            end
          end
        end
        ST_TAP1: tap_a <= tap_now;
        ST_TAP2: tap_b <= tap_now;
        ST_DIFF: begin
          d_q              <= d_now;
          running_diff_sum <= running_diff_sum + 32'(d_now);
          in_win_q         <= (t_now <= t_end) &&
                              (t_now + TW'(avg_count) >= t_end + TW'(1));
          at_end_q         <= t_now == t_end;
        end
        ST_MULM: pm_q <= pm_prod;
        ST_RSUM: begin
          r_q <= {{16{running_diff_sum[31]}}, running_diff_sum, 16'h0} + 64'(pm_q);
        end
        ST_SACC: shaper_accum <= shaper_accum + r_q;
        ST_ELO:  elo_q <= elo_prod;
        ST_EHI:  ehi_q <= ehi_prod[47:0];
        ST_EADD: energy_q <= energy_sum[47:16];
        ST_WIN: begin
          if (in_win_q) begin
            window_sum <= window_sum + {{16{energy_q[31]}}, energy_q};
          end
        end
        ST_PLO:  plo_q <= plo_prod;
        ST_PHI:  phi_q <= phi_prod[31:0];
        ST_PADD: peak_q <= phi_q + {8'h0, plo_q[47:24]};
        ST_DONE: begin
          if (out_free) begin
            write_pointer <= (write_pointer == AW'(DELAY_DEPTH - 1)) ?
                             '0 : write_pointer + AW'(1);
            if (run_q) begin
              since_start <= since_next;
              if (since_next >= SW'(MAX_RECORD)) begin
                active <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result register: holds a beat while the next sample is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_energy     <= run_q ? energy_q : '0;
      out_peak       <= (run_q && at_end_q) ? peak_q : '0;
      out_peak_valid <= run_q && at_end_q;
    end
  end

  assign data_out.valid       = out_valid;
  assign data_out.energy      = out_energy;
  assign data_out.peak_height = out_peak;
  assign data_out.peak_valid  = out_peak_valid;

  // A waiting result is never overwritten: the sequencer holds in its last step.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !data_out.ready) |=> state == ST_DONE)
    else $error("sequencer left its final step while the result was stalled");

  // A record never runs past its length.
  assert property (@(posedge clk) disable iff (rst)
    active |-> since_start < SW'(MAX_RECORD))
    else $error("record counter reached its limit while still active");

  // A sample outside a record gives an all-zero result.
  assert property (@(posedge clk) disable iff (rst)
    (done_fire && !run_q) |=>
      (out_valid && out_energy == '0 && !out_peak_valid && out_peak == '0))
    else $error("sample outside a record gave a non-zero result");

  // A new sample is only taken when the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != ST_IDLE && $past(state) == ST_IDLE))
    else $error("sample accepted outside the idle step");

endmodule
`default_nettype wire
